[hw/rtl/mcbp_pkg.sv]
// ----------------------------------------------------------------------------
// Byte pipe pool package
// Sizes, command and status codes, and the structs that pass between the
// pipe controller, the byte store and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mcbp_pkg;

  // Pool geometry.
  localparam int unsigned PIPE_COUNT   = 8;
  localparam int unsigned BUFFER_DEPTH = 256;

  // Field widths fixed by the interface.
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned ID_W   = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 3;

  // Derived widths.
  localparam int unsigned PIPE_IDX_W  = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
  localparam int unsigned PTR_W       = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W       = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned STORE_DEPTH = PIPE_COUNT * BUFFER_DEPTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE    = 3'd0,
    CMD_DESTROY   = 3'd1,
    CMD_CLOSE     = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_BLK  = 3'd4,
    CMD_READ_NB   = 3'd5,
    CMD_QUERY     = 3'd6
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_PIPE    = 3'd1,
    ST_FULL_RETRY  = 3'd2,
    ST_EMPTY_RETRY = 3'd3,
    ST_NO_DATA     = 3'd4,
    ST_NO_FREE     = 3'd5
  } status_e;

  // Result of one command, before the read byte is attached.
  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   new_id;
    logic              is_empty;
    logic              take;
  } res_t;

  // One access to the byte store.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  // Ring pointer advance with wrap at the end of the buffer.
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

endpackage : mcbp_pkg

`default_nettype wire

[hw/rtl/mcbp_ctrl.sv]
// ----------------------------------------------------------------------------
// Byte pipe controller
// Holds the per-pipe flags, pointers and counts, decodes one command per
// cycle, updates the pipe state and issues at most one byte store access.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbp_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      fire_i,
  input  wire logic [mcbp_pkg::CMD_W-1:0] cmd_i,
  input  wire logic [mcbp_pkg::ID_W-1:0]  id_i,
  input  wire logic [mcbp_pkg::BYTE_W-1:0] data_i,
  output mcbp_pkg::res_t                 res_o,
  output mcbp_pkg::mem_req_t             mem_req_o
);
  import mcbp_pkg::*;

  logic                  in_use_q [PIPE_COUNT];
  logic                  closed_q [PIPE_COUNT];
  logic [PTR_W-1:0]      head_q   [PIPE_COUNT];
  logic [PTR_W-1:0]      tail_q   [PIPE_COUNT];
  logic [CNT_W-1:0]      cnt_q    [PIPE_COUNT];

  logic [PIPE_IDX_W-1:0] idx;
  logic                  id_ok;
  logic                  free_found;
  logic [PIPE_IDX_W-1:0] free_idx;
  logic                  do_alloc, do_free, do_close, do_push, do_pop;
  logic [PTR_W-1:0]      slot;
  cmd_e                  cmd;

  assign cmd = cmd_e'(cmd_i);
  assign idx = id_i[PIPE_IDX_W-1:0];
  assign id_ok = ({1'b0, id_i} < (ID_W + 1)'(PIPE_COUNT)) && in_use_q[idx];

  // Lowest unused pipe.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = PIPE_IDX_W'(i);
      end
    end
  end

  always_comb begin
    do_alloc        = 1'b0;
    do_free         = 1'b0;
    do_close        = 1'b0;
    do_push         = 1'b0;
    do_pop          = 1'b0;
    res_o.status    = ST_OK;
    res_o.new_id    = '0;
    res_o.is_empty  = 1'b0;
    unique case (cmd)
      CMD_CREATE: begin
        if (free_found) begin
          do_alloc     = 1'b1;
          res_o.new_id = ID_W'(free_idx);
        end else begin
          res_o.status = ST_NO_FREE;
        end
      end
      CMD_QUERY: begin
        res_o.is_empty = !id_ok || (cnt_q[idx] == '0);
      end
      CMD_DESTROY: begin
        if (id_ok) do_free = 1'b1;
        else res_o.status = ST_BAD_PIPE;
      end
      CMD_CLOSE: begin
        if (id_ok) do_close = 1'b1;
        else res_o.status = ST_BAD_PIPE;
      end
      CMD_WRITE: begin
        if (!id_ok) res_o.status = ST_BAD_PIPE;
        else if (cnt_q[idx] == CNT_W'(BUFFER_DEPTH)) res_o.status = ST_FULL_RETRY;
        else do_push = 1'b1;
      end
      CMD_READ_BLK, CMD_READ_NB: begin
        if (!id_ok) res_o.status = ST_BAD_PIPE;
        else if (cnt_q[idx] != '0) do_pop = 1'b1;
        else if (cmd == CMD_READ_BLK && !closed_q[idx]) res_o.status = ST_EMPTY_RETRY;
        else res_o.status = ST_NO_DATA;
      end
      default: begin
        res_o.status = ST_BAD_PIPE;
      end
    endcase
    res_o.take = do_pop;
  end

  assign slot = do_push ? tail_q[idx] : head_q[idx];

  always_comb begin
    mem_req_o.we    = fire_i && do_push;
    mem_req_o.re    = fire_i && do_pop;
    mem_req_o.addr  = ADDR_W'(idx) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(slot);
    mem_req_o.wdata = data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_COUNT; i++) begin
        in_use_q[i] <= 1'b0;
        closed_q[i] <= 1'b0;
        head_q[i]   <= '0;
        tail_q[i]   <= '0;
        cnt_q[i]    <= '0;
      end
    end else if (fire_i) begin
      if (do_alloc) begin
        in_use_q[free_idx] <= 1'b1;
        closed_q[free_idx] <= 1'b0;
        head_q[free_idx]   <= '0;
        tail_q[free_idx]   <= '0;
        cnt_q[free_idx]    <= '0;
      end
      if (do_free)  in_use_q[idx] <= 1'b0;
      if (do_close) closed_q[idx] <= 1'b1;
      if (do_push) begin
        tail_q[idx] <= next_slot(tail_q[idx]);
        cnt_q[idx]  <= cnt_q[idx] + CNT_W'(1);
      end
      if (do_pop) begin
        head_q[idx] <= next_slot(head_q[idx]);
        cnt_q[idx]  <= cnt_q[idx] - CNT_W'(1);
      end
    end
  end

endmodule : mcbp_ctrl

`default_nettype wire

[hw/rtl/mcbp_store.sv]
// ----------------------------------------------------------------------------
// Byte store
// Single-port memory that holds the ring buffers of all pipes, with a
// registered read byte that holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbp_store (
  input  wire logic                        clk_i,
  input  mcbp_pkg::mem_req_t               req_i,
  output logic [mcbp_pkg::BYTE_W-1:0]      rdata_o
);
  import mcbp_pkg::*;

  logic [BYTE_W-1:0] store_q [STORE_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) store_q[req_i.addr] <= req_i.wdata;
    if (req_i.re) rdata_q <= store_q[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule : mcbp_store

`default_nettype wire

[hw/rtl/multi_channel_byte_pipe_fifo_unit.sv]
// ----------------------------------------------------------------------------
// Multi-channel byte pipe FIFO unit
// A pool of byte pipes, each a ring buffer in a shared byte store, driven by
// one command beat per cycle when not stalled and answering with one result beat per command.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o | command_i, pipe_id_i, data_byte_i
//   out     | output    | out_valid_o / out_stall_i | status_o, new_pipe_id_o,
//           |           |                        | read_byte_o, is_empty_o
//
// A command beat passes through the input register, the execute stage and
// the result register. It sustains one beat per cycle while the output is
// not stalled, bounded by the single read-modify-write of the per-pipe
// pointers and the single port of the byte store. Reset clears all pipe
// flags, pointers and counts at once; the byte store needs no clearing pass.
// A stall on the output holds the result register and backs up into the earlier
// stages only as they fill, so the unit keeps taking beats while bubbles remain.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_byte_pipe_fifo_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Command channel.
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [mcbp_pkg::CMD_W-1:0]   command_i,
  input  wire logic [mcbp_pkg::ID_W-1:0]    pipe_id_i,
  input  wire logic [mcbp_pkg::BYTE_W-1:0]  data_byte_i,
  // Result channel.
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [mcbp_pkg::STAT_W-1:0]       status_o,
  output logic [mcbp_pkg::ID_W-1:0]         new_pipe_id_o,
  output logic [mcbp_pkg::BYTE_W-1:0]       read_byte_o,
  output logic                              is_empty_o
);
  import mcbp_pkg::*;

  // Input register stage.
  logic              a_valid_q;
  logic [CMD_W-1:0]  a_cmd_q;
  logic [ID_W-1:0]   a_id_q;
  logic [BYTE_W-1:0] a_data_q;

  // Execute stage: the command result waits here while the store read lands.
  logic              b_valid_q;
  res_t              b_res_q;

  // Result register.
  logic              c_valid_q;
  logic [STAT_W-1:0] c_status_q;
  logic [ID_W-1:0]   c_new_id_q;
  logic [BYTE_W-1:0] c_rbyte_q;
  logic              c_empty_q;

  logic              a_ready, b_ready, c_ready;
  logic              a_load, b_load, c_load;
  res_t              res;
  mem_req_t          mem_req;
  logic [BYTE_W-1:0] rdata;

  // Each stage moves when the one after it is empty or moving too.
  assign c_ready = !c_valid_q || !out_stall_i;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;

  assign in_stall_o = !a_ready;
  assign a_load     = in_valid_i && a_ready;
  assign b_load     = a_valid_q && b_ready;
  assign c_load     = b_valid_q && c_ready;

  // The pipe state is updated in the same cycle that a command leaves the
  // input register, so the next command always sees the state it left.
  mcbp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (b_load),
    .cmd_i     (a_cmd_q),
    .id_i      (a_id_q),
    .data_i    (a_data_q),
    .res_o     (res),
    .mem_req_o (mem_req)
  );

  // The store read byte is only loaded by a read that moves into the
  // execute stage, so it stays put while that stage is held.
  mcbp_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_cmd_q  <= command_i;
      a_id_q   <= pipe_id_i;
      a_data_q <= data_byte_i;
    end
    if (b_load) begin
      b_res_q <= res;
    end
    if (c_load) begin
      c_status_q <= b_res_q.status;
      c_new_id_q <= b_res_q.new_id;
      c_rbyte_q  <= b_res_q.take ? rdata : '0;
      c_empty_q  <= b_res_q.is_empty;
    end
  end

  assign out_valid_o   = c_valid_q;
  assign status_o      = c_status_q;
  assign new_pipe_id_o = c_new_id_q;
  assign read_byte_o   = c_rbyte_q;
  assign is_empty_o    = c_empty_q;

`ifndef SYNTHESIS
  // With the result register empty every stage can move, so no beat is refused.
  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("command stalled while result register is empty");

  // A read byte only comes with a successful read.
  a_byte_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_byte_o != '0) |-> (status_o == ST_OK))
    else $error("read byte delivered with a failing status");

  // A nonzero allocated id only comes with a successful create.
  a_id_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (new_pipe_id_o != '0) |->
      (status_o == ST_OK) && (read_byte_o == '0) && !is_empty_o)
    else $error("allocated id delivered with another result");

  // A result beat waiting under stall never changes.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(read_byte_o) && $stable(new_pipe_id_o) && $stable(is_empty_o))
    else $error("stalled result beat changed");
`endif

endmodule : multi_channel_byte_pipe_fifo_unit

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Byte pipe pool testbench
// Drives command beats into the pipe pool and checks every result beat
// against a cycle-free predictor of the pool kept inside this file. A short
// table of hand-written commands comes first, then randomized bursts that
// allocate, fill, drain, close and free pipes, with random idle gaps on the
// command side and random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import mcbp_pkg::*;

  // The command field is three bits wide, so the one code without a meaning
  // is still sent and has to come back as a bad pipe.
  localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

  localparam int unsigned RANDOM_TARGET = 672;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned PRINT_CAP     = 100;

  typedef struct {
    status_e           status;
    logic [ID_W-1:0]   new_id;
    logic [BYTE_W-1:0] rbyte;
    logic              empty;
  } pipe_result_t;

  // One row of the directed table. When pinned is set, the result fields of
  // the row are the expected beat; otherwise the predictor supplies it.
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [BYTE_W-1:0] data;
    logic              pinned;
    status_e           status;
    logic [ID_W-1:0]   new_id;
    logic [BYTE_W-1:0] rbyte;
    logic              empty;
  } plan_row_t;

  // Clock, reset and the signals on the two channels. Every input of the
  // unit has a known value from time zero.
  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              cmd_valid  = 1'b0;
  logic [CMD_W-1:0]  cmd_code   = '0;
  logic [ID_W-1:0]   cmd_pipe   = '0;
  logic [BYTE_W-1:0] cmd_data   = '0;
  logic              res_stall  = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [STAT_W-1:0] status_o;
  logic [ID_W-1:0]   new_pipe_id_o;
  logic [BYTE_W-1:0] read_byte_o;
  logic              is_empty_o;

  // Expectation carried alongside a directed beat.
  logic              beat_pinned = 1'b0;
  pipe_result_t      beat_pin;

  // Mirror of the pool: per-pipe flags, ring pointers, fill counts and the
  // shared byte store.
  logic              pipe_used   [PIPE_COUNT] = '{default: 1'b0};
  logic              pipe_closed [PIPE_COUNT] = '{default: 1'b0};
  logic [PTR_W-1:0]  rd_ptr      [PIPE_COUNT] = '{default: '0};
  logic [PTR_W-1:0]  wr_ptr      [PIPE_COUNT] = '{default: '0};
  logic [CNT_W-1:0]  fill_level  [PIPE_COUNT] = '{default: '0};
  logic [BYTE_W-1:0] pipe_bytes  [STORE_DEPTH];

  pipe_result_t      pending_results [$];

  // When calm is set, the command side never idles and no new result stall
  // starts, which gives stretches of back-to-back beats in both directions.
  logic              calm         = 1'b0;
  int unsigned       cycle_count  = 0;
  int unsigned       beats_sent   = 0;
  int unsigned       beats_taken  = 0;
  int unsigned       results_seen = 0;
  int unsigned       mismatches   = 0;
  int unsigned       stall_left   = 0;
  int unsigned       status_tally [8] = '{default: 0};

  plan_row_t directed_plan [28] = '{
    // Queries and commands against pipes that were never allocated.
    '{CMD_QUERY,    4'd0,  8'h00, 1'b1, ST_OK,          4'd0, 8'h00, 1'b1},
    '{CMD_READ_NB,  4'd3,  8'h00, 1'b1, ST_BAD_PIPE,    4'd0, 8'h00, 1'b0},
    '{CMD_DESTROY,  4'd15, 8'h00, 1'b1, ST_BAD_PIPE,    4'd0, 8'h00, 1'b0},
    '{CMD_RESERVED, 4'd0,  8'h00, 1'b1, ST_BAD_PIPE,    4'd0, 8'h00, 1'b0},
    // Allocation ignores the id and hands out the lowest free pipe.
    '{CMD_CREATE,   4'd9,  8'hFF, 1'b1, ST_OK,          4'd0, 8'h00, 1'b0},
    '{CMD_CREATE,   4'd0,  8'h00, 1'b1, ST_OK,          4'd1, 8'h00, 1'b0},
    // Byte extremes through pipe 0, with both read styles on it while empty.
    '{CMD_READ_BLK, 4'd0,  8'h00, 1'b1, ST_EMPTY_RETRY, 4'd0, 8'h00, 1'b0},
    '{CMD_WRITE,    4'd0,  8'hFF, 1'b1, ST_OK,          4'd0, 8'h00, 1'b0},
    '{CMD_WRITE,    4'd0,  8'h00, 1'b1, ST_OK,          4'd0, 8'h00, 1'b0},
    '{CMD_QUERY,    4'd0,  8'h00, 1'b1, ST_OK,          4'd0, 8'h00, 1'b0},
    '{CMD_READ_BLK, 4'd0,  8'h00, 1'b1, ST_OK,          4'd0, 8'hFF, 1'b0},
    '{CMD_READ_NB,  4'd0,  8'h00, 1'b1, ST_OK,          4'd0, 8'h00, 1'b0},
    '{CMD_READ_NB,  4'd0,  8'h00, 1'b1, ST_NO_DATA,     4'd0, 8'h00, 1'b0},
    // Close pipe 1, keep writing to it, and drain it past the end.
    '{CMD_WRITE,    4'd1,  8'hA5, 1'b0, ST_OK,          4'd0, 8'h00, 1'b0},
    '{CMD_CLOSE,    4'd1,  8'h00, 1'b1, ST_OK,          4'd0, 8'h00, 1'b0},
    '{CMD_WRITE,    4'd1,  8'h5A, 1'b1, ST_OK,          4'd0, 8'h00, 1'b0},
    '{CMD_READ_BLK, 4'd1,  8'h00, 1'b1, ST_OK,          4'd0, 8'hA5, 1'b0},
    '{CMD_READ_BLK, 4'd1,  8'h00, 1'b0, ST_OK,          4'd0, 8'h00, 1'b0},
    '{CMD_READ_BLK, 4'd1,  8'h00, 1'b1, ST_NO_DATA,     4'd0, 8'h00, 1'b0},
    // Free pipe 1, poke at it, and allocate it again with a fresh state.
    '{CMD_DESTROY,  4'd1,  8'h00, 1'b1, ST_OK,          4'd0, 8'h00, 1'b0},
    '{CMD_WRITE,    4'd1,  8'h3C, 1'b1, ST_BAD_PIPE,    4'd0, 8'h00, 1'b0},
    '{CMD_QUERY,    4'd15, 8'h00, 1'b1, ST_OK,          4'd0, 8'h00, 1'b1},
    '{CMD_QUERY,    4'd1,  8'h00, 1'b1, ST_OK,          4'd0, 8'h00, 1'b1},
    '{CMD_CREATE,   4'd4,  8'h00, 1'b1, ST_OK,          4'd1, 8'h00, 1'b0},
    '{CMD_READ_BLK, 4'd1,  8'h00, 1'b1, ST_EMPTY_RETRY, 4'd0, 8'h00, 1'b0},
    '{CMD_WRITE,    4'd7,  8'h81, 1'b1, ST_BAD_PIPE,    4'd0, 8'h00, 1'b0},
    '{CMD_WRITE,    4'd14, 8'h7E, 1'b1, ST_BAD_PIPE,    4'd0, 8'h00, 1'b0},
    '{CMD_CLOSE,    4'd8,  8'h00, 1'b1, ST_BAD_PIPE,    4'd0, 8'h00, 1'b0}
  };

  multi_channel_byte_pipe_fifo_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (cmd_valid),
    .in_stall_o    (in_stall_o),
    .command_i     (cmd_code),
    .pipe_id_i     (cmd_pipe),
    .data_byte_i   (cmd_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (res_stall),
    .status_o      (status_o),
    .new_pipe_id_o (new_pipe_id_o),
    .read_byte_o   (read_byte_o),
    .is_empty_o    (is_empty_o)
  );

  always #4 clk_i = ~clk_i;

  // Advance a ring pointer by one slot, wrapping at the end of the buffer.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
    int unsigned n;
    n = int'(ptr) + 1;
    return (n == BUFFER_DEPTH) ? '0 : PTR_W'(n);
  endfunction

  // Applies one accepted command to the mirror of the pool and returns the
  // result beat the unit has to produce for it.
  function automatic pipe_result_t execute_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [BYTE_W-1:0] data);
    pipe_result_t res;
    logic         live;
    logic         found;
    int unsigned  p;
    int unsigned  addr;
    res.status = ST_OK;
    res.new_id = '0;
    res.rbyte  = '0;
    res.empty  = 1'b0;
    p    = id;
    live = 1'b0;
    if (p < PIPE_COUNT) begin
      live = pipe_used[p];
    end
    if (cmd == CMD_CREATE) begin
      found      = 1'b0;
      res.status = ST_NO_FREE;
      for (int i = 0; i < PIPE_COUNT; i++) begin
        if (!found && !pipe_used[i]) begin
          found          = 1'b1;
          pipe_used[i]   = 1'b1;
          pipe_closed[i] = 1'b0;
          rd_ptr[i]      = '0;
          wr_ptr[i]      = '0;
          fill_level[i]  = '0;
          res.new_id     = ID_W'(i);
          res.status     = ST_OK;
        end
      end
    end else if (cmd == CMD_QUERY) begin
      res.empty = !live || (fill_level[p] == '0);
    end else if (cmd == CMD_RESERVED || !live) begin
      res.status = ST_BAD_PIPE;
    end else if (cmd == CMD_DESTROY) begin
      pipe_used[p] = 1'b0;
    end else if (cmd == CMD_CLOSE) begin
      pipe_closed[p] = 1'b1;
    end else if (cmd == CMD_WRITE) begin
      if (fill_level[p] >= CNT_W'(BUFFER_DEPTH)) begin
        res.status = ST_FULL_RETRY;
      end else begin
        addr             = p * BUFFER_DEPTH + wr_ptr[p];
        pipe_bytes[addr] = data;
        wr_ptr[p]        = ring_next(wr_ptr[p]);
        fill_level[p]    = fill_level[p] + 1'b1;
      end
    end else if (fill_level[p] == '0) begin
      // Only a blocking read on a pipe that can still receive data retries.
      res.status = (cmd == CMD_READ_BLK && !pipe_closed[p]) ? ST_EMPTY_RETRY : ST_NO_DATA;
    end else begin
      addr          = p * BUFFER_DEPTH + rd_ptr[p];
      res.rbyte     = pipe_bytes[addr];
      rd_ptr[p]     = ring_next(rd_ptr[p]);
      fill_level[p] = fill_level[p] - 1'b1;
    end
    return res;
  endfunction

  // Idle length for either side: mostly from the lowest of three ranges, now and then from the highest.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  // A random allocated pipe, or any in-range id when none is allocated.
  function automatic logic [ID_W-1:0] live_pipe();
    int unsigned ids [$];
    for (int i = 0; i < PIPE_COUNT; i++) begin
      if (pipe_used[i]) ids.push_back(i);
    end
    if (ids.size() == 0) return ID_W'($urandom_range(0, PIPE_COUNT - 1));
    return ID_W'(ids[$urandom_range(0, ids.size() - 1)]);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    // Past the cap a broken run keeps counting without flooding the log.
    if (mismatches <= PRINT_CAP) $display("cycle %0d: mismatch: %s", cycle_count, msg);
  endtask

  // Puts one command beat on the channel and returns in the time step of
  // the edge that accepted it, with valid still high. The caller either
  // drives the next beat or lowers valid before time moves on.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [BYTE_W-1:0] data);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_length();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd_code  <= cmd;
    cmd_pipe  <= id;
    cmd_data  <= data;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // Holds the command side off until every outstanding result has come
  // back. The first edge lets the beat accepted in this step reach the
  // predictor, so its state is exact when the task returns.
  task automatic hold_until_drained();
    cmd_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("[multi_channel_byte_pipe_fifo_unit] ERROR");
      $finish;
    end
  end

  // Result side stalls: random bursts of stall; no new burst starts while calm.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      res_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      res_stall  <= 1'b1;
      stall_left <= idle_length() - 1;
    end else begin
      res_stall  <= 1'b0;
    end
  end

  // Every accepted command beat runs through the predictor. Directed rows
  // with a written-out result queue that result instead; the predictor
  // still runs so that its state follows the unit.
  always @(posedge clk_i) begin : command_accept
    pipe_result_t predicted;
    if (rst_ni && cmd_valid && !in_stall_o) begin
      predicted = execute_command(cmd_code, cmd_pipe, cmd_data);
      pending_results.push_back(beat_pinned ? beat_pin : predicted);
      status_tally[predicted.status]++;
      beats_taken++;
    end
  end

  // Every accepted result beat is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    pipe_result_t want;
    if (rst_ni && out_valid_o && !res_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding (status %0d)",
                                  status_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                    results_seen, status_o, want.status));
        if (new_pipe_id_o !== want.new_id)
          report_mismatch($sformatf("beat %0d new pipe id %0d, expected %0d",
                                    results_seen, new_pipe_id_o, want.new_id));
        if (read_byte_o !== want.rbyte)
          report_mismatch($sformatf("beat %0d read byte %02h, expected %02h",
                                    results_seen, read_byte_o, want.rbyte));
        if (is_empty_o !== want.empty)
          report_mismatch($sformatf("beat %0d empty flag %b, expected %b",
                                    results_seen, is_empty_o, want.empty));
      end
    end
  end

  initial begin : stimulus
    int               pick;
    int               n;
    logic [ID_W-1:0]  p;
    int unsigned      random_beats;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (directed_plan[k]) begin
      beat_pinned <= directed_plan[k].pinned;
      beat_pin    <= '{directed_plan[k].status, directed_plan[k].new_id,
                       directed_plan[k].rbyte, directed_plan[k].empty};
      send_command(directed_plan[k].cmd, directed_plan[k].id, directed_plan[k].data);
    end
    beat_pinned <= 1'b0;
    random_beats = beats_sent;

    // Exhaust the pool so that at least one allocation has to fail.
    hold_until_drained();
    repeat (PIPE_COUNT + 1) send_command(CMD_CREATE, ID_W'($urandom_range(0, 15)), 8'h00);

    // Fill one pipe past its depth, then drain it past empty, which also
    // wraps both of its ring pointers. The hold makes the fill level exact.
    hold_until_drained();
    p = live_pipe();
    n = BUFFER_DEPTH - fill_level[p] + 3;
    repeat (n) send_command(CMD_WRITE, p, BYTE_W'($urandom_range(0, 255)));
    repeat (BUFFER_DEPTH + 2) send_command(CMD_READ_BLK, p, BYTE_W'($urandom_range(0, 255)));

    // Random bursts: mostly well-formed traffic on allocated pipes, with
    // some raw noise over every code and id.
    while (beats_sent - random_beats < RANDOM_TARGET) begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_command(CMD_W'($urandom_range(0, 7)), ID_W'($urandom_range(0, 15)),
                     BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 42) begin
        p = live_pipe();
        repeat ($urandom_range(1, 12)) send_command(CMD_WRITE, p, BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 68) begin
        p = live_pipe();
        repeat ($urandom_range(1, 12)) begin
          send_command($urandom_range(0, 1) ? CMD_READ_BLK : CMD_READ_NB, p,
                       BYTE_W'($urandom_range(0, 255)));
        end
      end else if (pick < 77) begin
        send_command(CMD_CREATE, ID_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 83) begin
        send_command(CMD_DESTROY, live_pipe(), BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        send_command(CMD_CLOSE, live_pipe(), BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        p = $urandom_range(0, 3) == 0 ? ID_W'($urandom_range(0, 15)) : live_pipe();
        send_command(CMD_QUERY, p, BYTE_W'($urandom_range(0, 255)));
      end else begin
        hold_until_drained();
      end
    end

    // Let the last results come out, then keep watching for spurious beats.
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Sent %0d command beats (%0d from the directed table), checked %0d result beats.",
             beats_sent, $size(directed_plan), results_seen);
    $display("Status mix ok/bad/full/empty-retry/no-data/no-free: %0d/%0d/%0d/%0d/%0d/%0d",
             status_tally[ST_OK], status_tally[ST_BAD_PIPE], status_tally[ST_FULL_RETRY],
             status_tally[ST_EMPTY_RETRY], status_tally[ST_NO_DATA], status_tally[ST_NO_FREE]);
    if (mismatches == 0) begin
      $display("[multi_channel_byte_pipe_fifo_unit] OK");
    end else begin
      $display("[multi_channel_byte_pipe_fifo_unit] ERROR");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire
